// ----- src/mcw_pkg.sv -----
// shared types and constants for the multi-channel watchdog
`default_nettype none
package mcw_pkg;

   // fixed field widths of the request and response channels
   localparam int ID_BITS     = 4;
   localparam int TASK_BITS   = 8;
   localparam int PERIOD_BITS = 32;
   localparam int FUNC_BITS   = 2;

   // parameter defaults
   localparam int MONITORS_DEFAULT  = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   // request function codes
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_CONFIG = 2'd1,
      FUNC_KICK   = 2'd2
   } func_type;

   // per-cell control
   typedef struct packed {
      logic shift;
      logic config_we;
      logic kick_we;
   } cell_ctl_type;

   // tick sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage
`default_nettype wire

// ----- src/multi_channel_watchdog_unit.sv -----
// multi-channel watchdog: chain of slot cells and tick sequencer
`default_nettype none
// Each watchdog slot lives in its own cell; slot k sits in cell k while idle.
// A configure or kick transfer is written straight into the addressed cell.
// A tick rotates the whole chain once, one slot per cycle past the head
// cell where its countdown is checked and decremented, halting while an
// expiry meets a held-back notice and a stalled response side; the request
// side stalls until the tick is done. Expiry notices come out in ascending
// id order; one notice is held back until the next expiry or the end of
// the rotation shows whether it is the last of the tick. The request side
// may be accepted while a notice still waits in the output register.
module multi_channel_watchdog_unit #(
   parameter int MONITORS  = mcw_pkg::MONITORS_DEFAULT,
   parameter int TIME_BITS = mcw_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [mcw_pkg::FUNC_BITS-1:0]   req_func,
   input  wire logic [mcw_pkg::ID_BITS-1:0]     req_monitor_id,
   input  wire logic [mcw_pkg::PERIOD_BITS-1:0] req_period_ticks,
   input  wire logic [mcw_pkg::TASK_BITS-1:0]   req_owner_task,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [mcw_pkg::ID_BITS-1:0]          rsp_expired_monitor,
   output logic [mcw_pkg::TASK_BITS-1:0]        rsp_notify_task,
   output logic                                 rsp_last
);
   import mcw_pkg::*;

   localparam int CNT_BITS = $clog2(MONITORS + 1);

   // cell chain outputs
   logic                 c_valid     [MONITORS];
   logic                 c_armed     [MONITORS];
   logic [TIME_BITS-1:0] c_period    [MONITORS];
   logic [TIME_BITS-1:0] c_remaining [MONITORS];
   logic [TASK_BITS-1:0] c_owner     [MONITORS];
   cell_ctl_type         c_ctl       [MONITORS];

   // sequencer registers
   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]   pend_id_ff, pend_id_in;
   logic [TASK_BITS-1:0] pend_task_ff, pend_task_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [TASK_BITS-1:0] rsp_task_ff, rsp_task_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_xfer;
   logic                 shift;
   logic                 out_free;
   logic                 head_live;
   logic                 head_expire;
   logic                 head_armed;
   logic [TIME_BITS-1:0] head_remaining;
   logic [TIME_BITS-1:0] wr_period;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_period = TIME_BITS'(req_period_ticks);

   // head cell check: expire on zero countdown, else count down
   assign head_live      = c_valid[0] && c_armed[0];
   assign head_expire    = head_live && (c_remaining[0] == '0);
   assign head_armed     = c_armed[0] && !head_expire;
   assign head_remaining = (head_live && !head_expire) ? (c_remaining[0] - 1'b1)
                                                       : c_remaining[0];

   // cell chain
   for (genvar k = 0; k < MONITORS; k++) begin : g_cell
      assign c_ctl[k].shift     = shift;
      assign c_ctl[k].config_we = req_xfer && (func_type'(req_func) == FUNC_CONFIG)
                                  && (32'(req_monitor_id) == k);
      assign c_ctl[k].kick_we   = req_xfer && (func_type'(req_func) == FUNC_KICK)
                                  && (32'(req_monitor_id) == k);
      if (k == MONITORS - 1) begin : g_tail
         mcw_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (c_ctl[k]),
            .shin_valid     (c_valid[0]),
            .shin_armed     (head_armed),
            .shin_period    (c_period[0]),
            .shin_remaining (head_remaining),
            .shin_owner     (c_owner[0]),
            .wr_period      (wr_period),
            .wr_owner       (req_owner_task),
            .slot_valid     (c_valid[k]),
            .slot_armed     (c_armed[k]),
            .slot_period    (c_period[k]),
            .slot_remaining (c_remaining[k]),
            .slot_owner     (c_owner[k])
         );
      end else begin : g_body
         mcw_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (c_ctl[k]),
            .shin_valid     (c_valid[k+1]),
            .shin_armed     (c_armed[k+1]),
            .shin_period    (c_period[k+1]),
            .shin_remaining (c_remaining[k+1]),
            .shin_owner     (c_owner[k+1]),
            .wr_period      (wr_period),
            .wr_owner       (req_owner_task),
            .slot_valid     (c_valid[k]),
            .slot_armed     (c_armed[k]),
            .slot_period    (c_period[k]),
            .slot_remaining (c_remaining[k]),
            .slot_owner     (c_owner[k])
         );
      end
   end

   // tick sequencer: rotation, held-back notice, output register
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_task_in  = pend_task_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_last_in   = rsp_last_ff;
      shift         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (func_type'(req_func) == FUNC_TICK)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (!(head_expire && pend_valid_ff && !out_free)) begin
               shift  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (head_expire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = pend_id_ff;
                     rsp_task_in  = pend_task_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = ID_BITS'(cnt_ff);
                  pend_task_in  = c_owner[0];
               end
               if (cnt_ff == CNT_BITS'(MONITORS - 1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = pend_id_ff;
               rsp_task_in   = pend_task_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // notice payload registers
   always_ff @(posedge clock) begin
      pend_id_ff   <= pend_id_in;
      pend_task_ff <= pend_task_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_expired_monitor = rsp_id_ff;
   assign rsp_notify_task     = rsp_task_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire

// ----- src/mcw_cell.sv -----
// one watchdog slot of the rotating cell chain
`default_nettype none
module mcw_cell #(
   parameter int TIME_BITS = mcw_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mcw_pkg::cell_ctl_type         ctl,
   // slot handed over by the neighbor
   input  wire logic                          shin_valid,
   input  wire logic                          shin_armed,
   input  wire logic [TIME_BITS-1:0]          shin_period,
   input  wire logic [TIME_BITS-1:0]          shin_remaining,
   input  wire logic [mcw_pkg::TASK_BITS-1:0] shin_owner,
   // configure data
   input  wire logic [TIME_BITS-1:0]          wr_period,
   input  wire logic [mcw_pkg::TASK_BITS-1:0] wr_owner,
   // held slot
   output logic                               slot_valid,
   output logic                               slot_armed,
   output logic [TIME_BITS-1:0]               slot_period,
   output logic [TIME_BITS-1:0]               slot_remaining,
   output logic [mcw_pkg::TASK_BITS-1:0]      slot_owner
);
   import mcw_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [TIME_BITS-1:0] remaining_ff, remaining_in;
   logic [TASK_BITS-1:0] owner_ff, owner_in;

   // shift, configure or kick
   always_comb begin
      valid_in     = valid_ff;
      armed_in     = armed_ff;
      period_in    = period_ff;
      remaining_in = remaining_ff;
      owner_in     = owner_ff;
      if (ctl.shift) begin
         valid_in     = shin_valid;
         armed_in     = shin_armed;
         period_in    = shin_period;
         remaining_in = shin_remaining;
         owner_in     = shin_owner;
      end else if (ctl.config_we) begin
         valid_in     = 1'b1;
         armed_in     = 1'b1;
         period_in    = wr_period;
         remaining_in = wr_period;
         owner_in     = wr_owner;
      end else if (ctl.kick_we && valid_ff) begin
         armed_in     = 1'b1;
         remaining_in = period_ff;
      end
   end

   // control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         armed_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         armed_ff <= armed_in;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      remaining_ff <= remaining_in;
      owner_ff     <= owner_in;
   end

   assign slot_valid     = valid_ff;
   assign slot_armed     = armed_ff;
   assign slot_period    = period_ff;
   assign slot_remaining = remaining_ff;
   assign slot_owner     = owner_ff;

endmodule
`default_nettype wire
